>>> rtl/core/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at the rising edge, switched off while reset is held
`define UTBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at the rising edge, reset cycles included
`define UTBD_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> rtl/core/utbd_pkg.sv
// ============================================================================
// utbd_pkg
// Shared sizes, codes, tables and types of the base-n digit converter.
// ============================================================================
package utbd_pkg;

    // data path sizes
    localparam int VALUE_BITS = 32;
    localparam int MAX_BASE   = 16;
    localparam int DIG_W      = (MAX_BASE > 2) ? $clog2(MAX_BASE) : 1;
    localparam int RAD_W      = $clog2(MAX_BASE + 1);
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int IDX_W      = $clog2(VALUE_BITS);
    localparam int PROD_W     = 2 * VALUE_BITS;

    // register file sizes
    localparam int BASE_W     = 5;
    localparam int SYMTAB_W   = 64;
    localparam int SYM_W      = 2 * SYMTAB_W;
    localparam int CHAR_W     = 8;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 5;
    localparam int REGIDX_W   = 2;

    // register indexes
    localparam logic [REGIDX_W-1:0] REG_BASE   = 2'd0;
    localparam logic [REGIDX_W-1:0] REG_SYM_LO = 2'd1;
    localparam logic [REGIDX_W-1:0] REG_SYM_HI = 2'd2;

    // reset values: radix sixteen, symbols "0123456789abcdef"
    localparam logic [BASE_W-1:0]   BASE_RST   = 5'd16;
    localparam logic [SYMTAB_W-1:0] SYM_LO_RST = 64'h3736_3534_3332_3130;
    localparam logic [SYMTAB_W-1:0] SYM_HI_RST = 64'h6665_6463_6261_3938;

    // reciprocals floor((2^n - 1) / r): quotient estimate is exact or one low
    localparam logic [VALUE_BITS-1:0] ONES = '1;
    localparam logic [VALUE_BITS-1:0] RECIP [0:16] = '{
        ONES,      ONES,      ONES / 2,  ONES / 3,
        ONES / 4,  ONES / 5,  ONES / 6,  ONES / 7,
        ONES / 8,  ONES / 9,  ONES / 10, ONES / 11,
        ONES / 12, ONES / 13, ONES / 14, ONES / 15,
        ONES / 16
    };

    // back end sequencer
    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_FIX,
        B_EMIT
    } t_bstate;

    // configuration as seen by the back end
    typedef struct packed {
        logic [RAD_W-1:0] radix;
        logic [SYM_W-1:0] symbols;
    } t_cfg;

    // one queued value, classified by the front end
    typedef struct packed {
        logic [VALUE_BITS-1:0] value;
        logic                  zero;
    } t_entry;

    // queue status towards the back end
    typedef struct packed {
        logic   valid;
        t_entry head;
    } t_qhead;

endpackage

>>> rtl/core/unsigned_to_base_digits.sv
// ============================================================================
// unsigned_to_base_digits
// Converts an unsigned value into digit characters in a radix of 2 to 16.
// ============================================================================
// Usage:
//   Input: raise start with i_value; the beat is taken when busy is low.
//   A front stage and a two-entry queue hold up to three waiting values.
//   Output: one beat per digit on o_digit_char, most significant first,
//   o_strobe high for exactly one cycle per beat, o_last on the final one.
//   A zero value gives a single beat with o_empty_res and o_last set.
//   Configuration: APB-style port, registers at 0x00 (radix), 0x08 and
//   0x10 (symbols for digits 0-7 and 8-15); write only while idle.
// Sequencing:
//   Each digit takes a pass through the multiply-and-correct loop (reciprocal
//   multiply, then remainder fix-up); when the quotient reaches zero the
//   stored digits are played out, one beat each. A zero value skips the
//   loop and gives its single beat straight from the queue.
// Reset:
//   Synchronous, active low; empties the queue, idles the engine and loads
//   radix 16 with symbols "0123456789abcdef".
//   The receiver cannot stall; beats are never held back.
// ============================================================================
module unsigned_to_base_digits import utbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VALUE_BITS-1:0] i_value,
    output logic                  o_strobe,
    output logic [CHAR_W-1:0]     o_digit_char,
    output logic                  o_last,
    output logic                  o_empty_res,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [ADDR_W-1:0]     paddr,
    input  logic [DATA_W-1:0]     pwdata,
    output logic [DATA_W-1:0]     prdata,
    output logic                  pready
);

    t_cfg   w_cfg;
    t_entry w_entry;
    t_qhead w_head;
    logic   w_push;
    logic   w_pop;
    logic   w_full;

    // register file
    utbd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // input stage
    utbd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_value  (i_value),
        .i_q_full (w_full),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_entry  (w_entry)
    );

    // decoupling queue
    utbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_head  (w_head)
    );

    // conversion engine
    utbd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_head       (w_head),
        .o_pop        (w_pop),
        .o_strobe     (o_strobe),
        .o_digit_char (o_digit_char),
        .o_last       (o_last),
        .o_empty_res  (o_empty_res)
    );

endmodule

>>> rtl/core/utbd_cfg.sv
// ============================================================================
// utbd_cfg
// Register file with its bus port: radix and the sixteen digit symbols.
// ============================================================================
module utbd_cfg import utbd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    logic [BASE_W-1:0]   r_base;
    logic [SYMTAB_W-1:0] r_sym_lo;
    logic [SYMTAB_W-1:0] r_sym_hi;
    logic [REGIDX_W-1:0] w_idx;
    logic                w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[ADDR_W-1 -: REGIDX_W];
    assign w_wr   = psel && penable && pwrite && pready;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base   <= BASE_RST;
            r_sym_lo <= SYM_LO_RST;
            r_sym_hi <= SYM_HI_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_BASE:   r_base   <= pwdata[BASE_W-1:0];
                REG_SYM_LO: r_sym_lo <= pwdata[SYMTAB_W-1:0];
                REG_SYM_HI: r_sym_hi <= pwdata[SYMTAB_W-1:0];
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (w_idx)
            REG_BASE:   prdata = DATA_W'(r_base);
            REG_SYM_LO: prdata = DATA_W'(r_sym_lo);
            REG_SYM_HI: prdata = DATA_W'(r_sym_hi);
            default:    prdata = '0;
        endcase
    end

    // radix in use, clamped to the supported range
    always_comb begin
        if (r_base < BASE_W'(2)) begin
            o_cfg.radix = RAD_W'(2);
        end else if (r_base > BASE_W'(MAX_BASE)) begin
            o_cfg.radix = RAD_W'(MAX_BASE);
        end else begin
            o_cfg.radix = r_base[RAD_W-1:0];
        end
        o_cfg.symbols = {r_sym_hi, r_sym_lo};
    end

endmodule

>>> rtl/core/utbd_front.sv
// ============================================================================
// utbd_front
// Input stage: takes a value, flags a zero value, hands it to the queue.
// ============================================================================
module utbd_front import utbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_q_full,
    output logic                  o_busy,
    output logic                  o_push,
    output t_entry                o_entry
);

    logic   r_valid;
    t_entry r_entry;
    logic   w_take;

    assign o_busy  = r_valid && i_q_full;
    assign w_take  = i_start && !o_busy;
    assign o_push  = r_valid && !i_q_full;
    assign o_entry = r_entry;

    // holding stage in front of the queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // classify on entry
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_entry.value <= i_value;
            r_entry.zero  <= (i_value == '0);
        end
    end

endmodule

>>> rtl/core/utbd_queue.sv
// ============================================================================
// utbd_queue
// Two-entry queue between the front and back ends.
// ============================================================================
module utbd_queue import utbd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    input  logic   i_pop,
    output logic   o_full,
    output t_qhead o_head
);

    t_entry     r_mem [0:1];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;

    assign o_full       = (r_cnt == 2'd2);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.head  = r_mem[r_rptr];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= !r_wptr;
            end
            if (i_pop) begin
                r_rptr <= !r_rptr;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

endmodule

>>> rtl/core/utbd_back.sv
// ============================================================================
// utbd_back
// Conversion engine: divides by the radix one digit at a time, keeps the
// digits, then plays them out most significant first.
// ============================================================================
module utbd_back import utbd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  t_qhead            i_head,
    output logic              o_pop,
    output logic              o_strobe,
    output logic [CHAR_W-1:0] o_digit_char,
    output logic              o_last,
    output logic              o_empty_res
);

    t_bstate                r_state;
    t_bstate                n_state;
    logic [VALUE_BITS-1:0]  r_quot;
    logic [PROD_W-1:0]      r_prod;
    logic [CNT_W-1:0]       r_count;
    logic [DIG_W-1:0]       r_digits [0:VALUE_BITS-1];

    logic                   r_strobe;
    logic [CHAR_W-1:0]      r_char;
    logic                   r_last;
    logic                   r_empty;
    logic                   n_strobe;
    logic [CHAR_W-1:0]      n_char;
    logic                   n_last;
    logic                   n_empty;

    logic [VALUE_BITS-1:0]  w_q0;
    logic [VALUE_BITS-1:0]  w_qr;
    logic [VALUE_BITS-1:0]  w_r0;
    logic [RAD_W:0]         w_rem;
    logic [RAD_W:0]         w_rad;
    logic [RAD_W:0]         w_rem_fix;
    logic                   w_ge;
    logic [DIG_W-1:0]       w_digit;
    logic [VALUE_BITS-1:0]  w_qnext;
    logic [CNT_W-1:0]       w_rd_cnt;
    logic [DIG_W-1:0]       w_rd_digit;
    logic [3:0]             w_sidx;

    // quotient estimate correction: remainder lands below twice the radix
    assign w_q0      = r_prod[PROD_W-1 -: VALUE_BITS];
    assign w_qr      = w_q0 * VALUE_BITS'(i_cfg.radix);
    assign w_r0      = r_quot - w_qr;
    assign w_rem     = w_r0[RAD_W:0];
    assign w_rad     = (RAD_W + 1)'(i_cfg.radix);
    assign w_ge      = (w_rem >= w_rad);
    assign w_rem_fix = w_ge ? (w_rem - w_rad) : w_rem;
    assign w_digit   = w_rem_fix[DIG_W-1:0];
    assign w_qnext   = w_q0 + VALUE_BITS'(w_ge);

    // digit read-out, newest first
    assign w_rd_cnt   = r_count - CNT_W'(1);
    assign w_rd_digit = r_digits[w_rd_cnt[IDX_W-1:0]];
    assign w_sidx     = 4'(w_rd_digit);

    assign o_pop = (r_state == B_IDLE) && i_head.valid;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (i_head.valid && !i_head.head.zero) begin
                    n_state = B_MUL;
                end
            end
            B_MUL: begin
                n_state = B_FIX;
            end
            B_FIX: begin
                n_state = (w_qnext == '0) ? B_EMIT : B_MUL;
            end
            B_EMIT: begin
                if (r_count == CNT_W'(1)) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // result beat
    always_comb begin
        n_strobe = 1'b0;
        n_char   = '0;
        n_last   = 1'b0;
        n_empty  = 1'b0;
        case (r_state)
            B_IDLE: begin
                if (i_head.valid && i_head.head.zero) begin
                    n_strobe = 1'b1;
                    n_last   = 1'b1;
                    n_empty  = 1'b1;
                end
            end
            B_EMIT: begin
                n_strobe = 1'b1;
                n_char   = i_cfg.symbols[{w_sidx, 3'b000} +: CHAR_W];
                n_last   = (r_count == CNT_W'(1));
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_strobe <= 1'b0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            case (r_state)
                B_IDLE:  r_count <= '0;
                B_FIX:   r_count <= r_count + CNT_W'(1);
                B_EMIT:  r_count <= w_rd_cnt;
                default: r_count <= r_count;
            endcase
        end
    end

    // data path registers
    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_last  <= n_last;
        r_empty <= n_empty;
        case (r_state)
            B_IDLE: begin
                r_quot <= i_head.head.value;
            end
            B_MUL: begin
                r_prod <= {{VALUE_BITS{1'b0}}, r_quot}
                        * {{VALUE_BITS{1'b0}}, RECIP[i_cfg.radix]};
            end
            B_FIX: begin
                r_quot                       <= w_qnext;
                r_digits[r_count[IDX_W-1:0]] <= w_digit;
            end
            default: ;
        endcase
    end

    assign o_strobe     = r_strobe;
    assign o_digit_char = r_char;
    assign o_last       = r_last;
    assign o_empty_res  = r_empty;

endmodule

>>> rtl/core/utbd_checker.sv
// ============================================================================
// utbd_checker
// Port-level checks on the digit converter, bound to the top level.
// ============================================================================
`include "assert_macros.svh"

module utbd_checker import utbd_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  busy,
    input logic                  o_strobe,
    input logic [CHAR_W-1:0]     o_digit_char,
    input logic                  o_last,
    input logic                  o_empty_res
);

    logic w_empty_beat;

    assign w_empty_beat = o_strobe && o_empty_res;

    // an empty result is always the whole string
    `UTBD_ASSERT(a_empty_last, w_empty_beat |-> o_last, "empty beat without last")

    // an empty result carries no character
    `UTBD_ASSERT(a_empty_char, w_empty_beat |-> (o_digit_char == '0), "empty beat with a char")

    // digits of one value follow each other without gaps
    `UTBD_ASSERT(a_no_gap, (o_strobe && !o_last) |=> o_strobe, "gap inside a digit string")

    // reset leaves the block idle and quiet
    `UTBD_ASSERT_ANY(a_reset_idle, !i_rst_n |=> (!o_strobe && !busy), "not idle after reset")

endmodule

bind unsigned_to_base_digits utbd_checker u_utbd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .busy         (busy),
    .o_strobe     (o_strobe),
    .o_digit_char (o_digit_char),
    .o_last       (o_last),
    .o_empty_res  (o_empty_res)
);
